// ===== design/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types and constants of the latency histogram unit.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int unsigned DEF_EXACT_BUCKETS  = 256;
    localparam int unsigned DEF_FINE_BUCKETS   = 256;
    localparam int unsigned DEF_COARSE_BUCKETS = 256;
    // bucket widths are powers of two so the slot comes from a shift
    localparam int unsigned DEF_FINE_WIDTH     = 16;
    localparam int unsigned DEF_COARSE_WIDTH   = 1024;

    localparam int unsigned PCT_W   = 14;
    localparam int unsigned CNT_W   = 32;
    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(10000);

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic take;       // latch the input item
        logic clr_step;   // write zero at the sweep address, advance it
        logic rd_issue;   // read bucket at the walk/record address
        logic rec_write;  // write back the incremented bucket, update stats
        logic rd_latch;   // latch the scaled count of the bucket just read
        logic mul_step;   // one shift-add step of the target product
        logic walk_step;  // accumulate a bucket and compare against target
        logic finish;     // load the output register
    } lhp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic mul_done;
        logic walk_hit;
        logic walk_end;
        logic q_direct;   // query answered without a walk
    } lhp_sts_t;

endpackage

// ===== design/lhp_ram.sv =====
// ----------------------------------------------------------------------------
// lhp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lhp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 769
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/lhp_datapath.sv =====
// ----------------------------------------------------------------------------
// lhp_datapath
// Operand latch, bucket store, statistics, rank arithmetic and walk.
// ----------------------------------------------------------------------------
module lhp_datapath import lhp_pkg::*; #(
    parameter int unsigned EXACT_BUCKETS  = DEF_EXACT_BUCKETS,
    parameter int unsigned FINE_BUCKETS   = DEF_FINE_BUCKETS,
    parameter int unsigned COARSE_BUCKETS = DEF_COARSE_BUCKETS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  lhp_cmd_t     cmd,
    output lhp_sts_t     sts,
    input  logic [1:0]   in_op,
    input  logic [63:0]  in_start,
    input  logic [63:0]  in_end,
    input  logic [13:0]  in_pct,
    output logic [63:0]  pct_value,
    output logic         sample_rejected,
    output logic [63:0]  valid_count,
    output logic [63:0]  bad_count,
    output logic [63:0]  least_ns,
    output logic [63:0]  most_ns,
    output logic [63:0]  sum_ns
);

    localparam int unsigned FINE_WIDTH   = DEF_FINE_WIDTH;
    localparam int unsigned COARSE_WIDTH = DEF_COARSE_WIDTH;
    localparam int unsigned NB     = EXACT_BUCKETS + FINE_BUCKETS + COARSE_BUCKETS + 1;
    localparam int unsigned AW     = $clog2(NB);
    localparam int unsigned OVF    = NB - 1;
    localparam int unsigned FSTART = EXACT_BUCKETS;
    localparam int unsigned CSTART = EXACT_BUCKETS + FINE_BUCKETS;
    localparam logic [64:0] FINE_SPAN   = 65'(FINE_BUCKETS) * 65'(FINE_WIDTH);
    localparam logic [64:0] COARSE_SPAN = 65'(COARSE_BUCKETS) * 65'(COARSE_WIDTH);
    localparam int unsigned FSH = $clog2(FINE_WIDTH);
    localparam int unsigned CSH = $clog2(COARSE_WIDTH);
    localparam int unsigned MUL_STEPS = PCT_W;
    localparam int unsigned TGT_W = 64 + PCT_W;

    // latched item
    logic [1:0]       op_reg;
    logic [63:0]      dur_reg;
    logic             rej_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [AW-1:0]    slot_reg;

    // statistics
    logic [63:0] total_reg, bad_reg, min_reg, max_reg, sum_reg;

    // sweep / walk address
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] walk_reg;    // index of the bucket whose count is in scaled_reg
    logic [63:0]   acc_reg;     // running bucket sum times 10000
    logic [45:0]   scaled_reg;

    // target count*p, compared against the scaled running sum
    logic [TGT_W-1:0] prod_reg;
    logic [3:0]       mcnt_reg;

    logic [63:0] out_val_reg;

    // ---------------------------------------------------------------- slot
    logic [64:0] off_f, off_c;
    logic [AW-1:0] slot_calc;
    logic [63:0] dur_in;

    assign dur_in = in_end - in_start;

    always_comb
    begin
        off_f = {1'b0, dur_in} - 65'(EXACT_BUCKETS);
        off_c = off_f - FINE_SPAN;
        if ({1'b0, dur_in} < 65'(EXACT_BUCKETS))
        begin
            slot_calc = AW'(dur_in);
        end
        else if (off_f < FINE_SPAN)
        begin
            slot_calc = AW'(FSTART) + AW'(off_f >> FSH);
        end
        else if (off_c < COARSE_SPAN)
        begin
            slot_calc = AW'(CSTART) + AW'(off_c >> CSH);
        end
        else
        begin
            slot_calc = AW'(OVF);
        end
    end

    // ---------------------------------------------------------------- upper bound
    function automatic logic [63:0] slot_top(input logic [AW-1:0] i);
        logic [63:0] k;
        begin
            if (64'(i) < 64'(EXACT_BUCKETS))
            begin
                return 64'(i);
            end
            k = 64'(i) - 64'(EXACT_BUCKETS);
            if (k < 64'(FINE_BUCKETS))
            begin
                return 64'(EXACT_BUCKETS) + (k + 64'd1) * 64'(FINE_WIDTH) - 64'd1;
            end
            k = k - 64'(FINE_BUCKETS);
            return 64'(EXACT_BUCKETS) + FINE_SPAN[63:0] + (k + 64'd1) * 64'(COARSE_WIDTH)
                   - 64'd1;
        end
    endfunction

    // ---------------------------------------------------------------- RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    always_comb
    begin
        ram_we    = cmd.clr_step || (cmd.rec_write && !rej_reg);
        ram_waddr = cmd.clr_step ? addr_reg : slot_reg;
        ram_wdata = cmd.clr_step ? 32'd0
                  : ((ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1);
        ram_raddr = (op_reg == OP_RECORD) ? slot_reg : addr_reg;
    end

    lhp_ram #(.WIDTH(CNT_W), .DEPTH(NB)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- status
    // acc*10000 >= count*p holds exactly when acc reaches ceil(count*p/10000)
    logic [45:0] scaled_calc;
    logic [63:0] acc_sum;
    assign scaled_calc = (46'(ram_rdata) << 13) + (46'(ram_rdata) << 10)
                       + (46'(ram_rdata) << 9) + (46'(ram_rdata) << 8)
                       + (46'(ram_rdata) << 4);
    assign acc_sum = acc_reg + 64'(scaled_reg);

    always_comb
    begin
        sts.clr_done  = (addr_reg == AW'(OVF));
        sts.mul_done  = (mcnt_reg == 4'(MUL_STEPS - 1));
        sts.walk_hit  = (TGT_W'(acc_sum) >= prod_reg);
        sts.walk_end  = (walk_reg == AW'(OVF));
        sts.q_direct  = (total_reg == 64'd0) || (pct_reg == '0) || (pct_reg >= PCT_FULL);
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= '0;
            bad_reg         <= '0;
            min_reg         <= '1;
            max_reg         <= '0;
            sum_reg         <= '0;
            addr_reg        <= '0;
            op_reg          <= OP_CLEAR;
            rej_reg         <= 1'b0;
            pct_value       <= '0;
            sample_rejected <= 1'b0;
            valid_count     <= '0;
            bad_count       <= '0;
            least_ns        <= '1;
            most_ns         <= '0;
            sum_ns          <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                op_reg  <= in_op;
                dur_reg <= dur_in;
                rej_reg <= (in_op == OP_RECORD) && (in_end < in_start);
                pct_reg <= in_pct;
                slot_reg <= slot_calc;
                addr_reg <= '0;
                acc_reg  <= '0;
                walk_reg <= '0;
                mcnt_reg <= '0;
                prod_reg <= '0;
                if (in_op == OP_CLEAR)
                begin
                    total_reg <= '0;
                    bad_reg   <= '0;
                    min_reg   <= '1;
                    max_reg   <= '0;
                    sum_reg   <= '0;
                end
            end
            if (cmd.clr_step)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (cmd.rec_write)
            begin
                if (rej_reg)
                begin
                    bad_reg <= bad_reg + 64'd1;
                end
                else
                begin
                    total_reg <= total_reg + 64'd1;
                    sum_reg   <= sum_reg + dur_reg;
                    if (dur_reg < min_reg) min_reg <= dur_reg;
                    if (dur_reg > max_reg) max_reg <= dur_reg;
                end
            end
            // shift-add product count*p, one bit of p a step (MSB first)
            if (cmd.mul_step)
            begin
                mcnt_reg <= mcnt_reg + 4'd1;
                prod_reg <= {prod_reg[TGT_W-2:0], 1'b0}
                          + (pct_reg[4'(MUL_STEPS - 1) - mcnt_reg] ? TGT_W'(total_reg)
                                                                   : {TGT_W{1'b0}});
            end
            if (cmd.rd_issue)
            begin
                walk_reg <= addr_reg;
                addr_reg <= addr_reg + AW'(1);
            end
            if (cmd.rd_latch)
            begin
                scaled_reg <= scaled_calc;
            end
            if (cmd.walk_step)
            begin
                acc_reg <= acc_sum;
            end
            if (cmd.finish)
            begin
                pct_value       <= out_val_reg;
                sample_rejected <= (op_reg == OP_RECORD) && rej_reg;
                valid_count     <= total_reg;
                bad_count       <= bad_reg;
                least_ns        <= min_reg;
                most_ns         <= max_reg;
                sum_ns          <= sum_reg;
            end
        end
    end

    // answer of the item
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            out_val_reg <= '0;
        end
        else if (op_reg == OP_QUERY)
        begin
            if (sts.q_direct)
            begin
                out_val_reg <= (total_reg == 64'd0) ? 64'd0
                             : (pct_reg == '0) ? min_reg : max_reg;
            end
            else if (cmd.walk_step)
            begin
                out_val_reg <= (!sts.walk_hit || walk_reg == AW'(OVF)) ? max_reg
                             : slot_top(walk_reg);
            end
        end
    end

endmodule

// ===== design/lhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhp_ctrl
// Sequencer for record, query, clear and the reset clearing sweep.
// ----------------------------------------------------------------------------
module lhp_ctrl import lhp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] in_op,
    input  lhp_sts_t   sts,
    output lhp_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_RREAD  = 10'b0000000100,
        S_RWRITE = 10'b0000001000,
        S_MUL    = 10'b0000010000,
        S_RANK   = 10'b0000100000,
        S_ISSUE  = 10'b0001000000,
        S_WALK   = 10'b0010000000,
        S_DONE   = 10'b0100000000,
        S_SETTLE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid && !out_ready;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_IDLE:
            begin
                in_ready = !out_valid || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.take = 1'b1;
                    unique case (in_op)
                        OP_RECORD: state_next = S_RREAD;
                        OP_QUERY:  state_next = S_SETTLE;
                        OP_CLEAR:  state_next = S_CLEAR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_RREAD:  state_next = S_RWRITE;
            S_RWRITE:
            begin
                cmd.rec_write = 1'b1;
                state_next    = S_DONE;
            end
            S_SETTLE: state_next = sts.q_direct ? S_DONE : S_MUL;
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_done) state_next = S_RANK;
            end
            S_RANK:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_ISSUE;
            end
            S_ISSUE:
            begin
                // count of the issued bucket is on the read port now
                cmd.rd_latch = 1'b1;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_hit || sts.walk_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_ISSUE;
                end
            end
            S_DONE:
            begin
                if (!out_valid || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // the reset sweep ends in S_DONE; hide that one result
    logic sweep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid <= 1'b0;
            sweep_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.finish && sweep_reg)
            begin
                out_valid <= 1'b0;
                sweep_reg <= 1'b0;
            end
            else
            begin
                out_valid <= out_valid_next;
            end
        end
    end

endmodule

// ===== design/latency_histogram_percentile_unit.sv =====
// ----------------------------------------------------------------------------
// latency_histogram_percentile_unit
// Tiered latency histogram with count/sum/min/max and percentile queries.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                               | tuser
// s_axis  | in  | from_ns[63:0] end_ns[127:64] pct[141:128]        | op[1:0]
// m_axis  | out | pct_value, valid_count, bad_count, least_ns,     | sample_rejected
//         |     | most_ns, sum_ns (64 bits each)                   |
//
// Record: bucket read, write back, result. Clear: every bucket written zero,
// then the result. Query: a direct answer when no walk is needed, otherwise
// a shift-add product of count and pct, then a walk over the buckets.
// After reset the bucket RAM is swept with no item taken.
// A stalled result holds in the output register; the next item waits.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_unit import lhp_pkg::*; #(
    parameter int unsigned EXACT_BUCKETS  = DEF_EXACT_BUCKETS,
    parameter int unsigned FINE_BUCKETS   = DEF_FINE_BUCKETS,
    parameter int unsigned COARSE_BUCKETS = DEF_COARSE_BUCKETS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // from_ns, end_ns, pct_hundredths, pad
    input  logic [1:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [383:0] m_axis_tdata,   // pct_value, valid_count, bad_count,
                                         // least_ns, most_ns, sum_ns
    output logic         m_axis_tuser    // sample_rejected
);

    lhp_cmd_t cmd;
    lhp_sts_t sts;

    lhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .in_op     (s_axis_tuser),
        .sts       (sts),
        .cmd       (cmd)
    );

    lhp_datapath #(
        .EXACT_BUCKETS  (EXACT_BUCKETS),
        .FINE_BUCKETS   (FINE_BUCKETS),
        .COARSE_BUCKETS (COARSE_BUCKETS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_op           (s_axis_tuser),
        .in_start        (s_axis_tdata[63:0]),
        .in_end          (s_axis_tdata[127:64]),
        .in_pct          (s_axis_tdata[141:128]),
        .pct_value       (m_axis_tdata[63:0]),
        .sample_rejected (m_axis_tuser),
        .valid_count     (m_axis_tdata[127:64]),
        .bad_count       (m_axis_tdata[191:128]),
        .least_ns        (m_axis_tdata[255:192]),
        .most_ns         (m_axis_tdata[319:256]),
        .sum_ns          (m_axis_tdata[383:320])
    );

endmodule

// ===== design/lhp_checker.sv =====
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks of the latency histogram unit.
// ----------------------------------------------------------------------------
module lhp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [383:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // one item in flight: no input taken while a result waits unaccepted
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("item taken while result stalled");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a rejected sample reports no percentile answer
    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("rejected record with nonzero value");

    // empty statistics show least all ones
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[127:64] == 64'd0)
        |-> (m_axis_tdata[255:192] == '1))
        else $error("empty monitor with finite minimum");

endmodule

bind latency_histogram_percentile_unit lhp_checker u_lhp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/latency_histogram_percentile_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latency_histogram_percentile_unit_tb
// Drives records, percentile queries and clears into the latency histogram
// unit and checks every result against a bucket-level model kept in the
// bench. A directed table covers the extremes and special cases, then a
// random mix of records, queries, clears and no-op items follows, with bursty input and
// a stalling output side.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_unit_tb;
    import lhp_pkg::*;

    localparam int unsigned NEXACT   = DEF_EXACT_BUCKETS;
    localparam int unsigned NFINE    = DEF_FINE_BUCKETS;
    localparam int unsigned FWIDTH   = DEF_FINE_WIDTH;
    localparam int unsigned NCOARSE  = DEF_COARSE_BUCKETS;
    localparam int unsigned CWIDTH   = DEF_COARSE_WIDTH;
    localparam int unsigned NSLOTS   = NEXACT + NFINE + NCOARSE + 1;
    localparam int unsigned OVF_SLOT = NEXACT + NFINE + NCOARSE;
    localparam longint unsigned FSPAN = longint'(NFINE) * FWIDTH;
    localparam longint unsigned CSPAN = longint'(NCOARSE) * CWIDTH;
    localparam int unsigned N_RANDOM = 600;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        op_t         op;
        logic [63:0] from_ns;
        logic [63:0] end_ns;
        logic [13:0] pct;
    } req_t;

    typedef struct packed {
        logic [63:0] pct_value;
        logic        rejected;
        logic [63:0] valid_count;
        logic [63:0] bad_count;
        logic [63:0] least_ns;
        logic [63:0] most_ns;
        logic [63:0] sum_ns;
    } stats_t;

    // directed row: item plus an optional typed-in answer
    typedef struct {
        req_t   req;
        logic   known;
        stats_t res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;   // from_ns, end_ns, pct_hundredths, pad
    logic [1:0]   s_axis_tuser;   // op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [383:0] m_axis_tdata;   // pct_value, valid_count, bad_count,
                                  // least_ns, most_ns, sum_ns
    logic         m_axis_tuser;   // sample_rejected

    latency_histogram_percentile_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // histogram mirror
    logic [31:0] hist [NSLOTS];
    logic [63:0] n_good, n_bad, lo_ns, hi_ns, tot_ns;

    stats_t expected_q [$];
    int     errors;
    int     idle_cycles;
    bit     hold_off;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned bucket_of(logic [63:0] d);
        if (d < NEXACT)
            return int'(d);
        d = d - NEXACT;
        if (d < FSPAN)
            return NEXACT + int'(d / FWIDTH);
        d = d - FSPAN;
        if (d < CSPAN)
            return NEXACT + NFINE + int'(d / CWIDTH);
        return OVF_SLOT;
    endfunction

    function automatic logic [63:0] bucket_top(int unsigned i);
        if (i < NEXACT)
            return 64'(i);
        if (i < NEXACT + NFINE)
            return 64'(NEXACT) + 64'(i - NEXACT + 1) * FWIDTH - 1;
        return 64'(NEXACT) + FSPAN + 64'(i - NEXACT - NFINE + 1) * CWIDTH - 1;
    endfunction

    task automatic clear_hist();
        foreach (hist[i])
            hist[i] = '0;
        n_good = '0;
        n_bad  = '0;
        lo_ns  = ALL_ONES;
        hi_ns  = '0;
        tot_ns = '0;
    endtask

    function automatic logic [63:0] percentile_of(logic [13:0] p);
        logic [127:0] rank;
        logic [127:0] acc;
        if (n_good == 0)
            return '0;
        if (p == 0)
            return lo_ns;
        if (p >= PCT_FULL)
            return hi_ns;
        rank = (128'(n_good) * p + 9999) / 10000;
        if (rank == 0)
            rank = 1;
        acc = '0;
        for (int unsigned i = 0; i < NSLOTS; i++)
        begin
            acc = acc + hist[i];
            if (acc >= rank)
                return (i == OVF_SLOT) ? hi_ns : bucket_top(i);
        end
        return hi_ns;
    endfunction

    // advance the mirror by one item and return the resulting status
    task automatic apply_item(input req_t r, output stats_t s);
        logic [63:0] d;
        int unsigned k;
        s = '0;
        case (r.op)
            OP_RECORD:
            begin
                if (r.end_ns < r.from_ns)
                begin
                    n_bad = n_bad + 1;
                    s.rejected = 1'b1;
                end
                else
                begin
                    d = r.end_ns - r.from_ns;
                    k = bucket_of(d);
                    if (hist[k] != 32'hFFFF_FFFF)
                        hist[k] = hist[k] + 1;
                    n_good = n_good + 1;
                    tot_ns = tot_ns + d;
                    if (d < lo_ns)
                        lo_ns = d;
                    if (d > hi_ns)
                        hi_ns = d;
                end
            end
            OP_QUERY:  s.pct_value = percentile_of(r.pct);
            OP_CLEAR:  clear_hist();
            default:   ;
        endcase
        s.valid_count = n_good;
        s.bad_count   = n_bad;
        s.least_ns    = lo_ns;
        s.most_ns     = hi_ns;
        s.sum_ns      = tot_ns;
    endtask

    task automatic send_item(input req_t r);
        s_axis_tdata  <= {2'b00, r.pct, r.end_ns, r.from_ns};
        s_axis_tuser  <= r.op;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_item(input req_t r, input logic known, input stats_t typed);
        stats_t s;
        apply_item(r, s);
        if (known && s != typed)
        begin
            $error("directed row disagrees with model: want %h got %h", typed, s);
            errors++;
        end
        expected_q.push_back(known ? typed : s);
        send_item(r);
        // gap between bursts
        if ($urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    function automatic req_t rand_item();
        req_t r;
        int unsigned sel;
        logic [63:0] d;
        r.pct = 14'($urandom);
        r.from_ns = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0:       d = 64'($urandom_range(0, NEXACT - 1));
            1:       d = 64'($urandom_range(NEXACT, NEXACT + FSPAN - 1));
            2:       d = 64'($urandom_range(NEXACT + FSPAN, NEXACT + FSPAN + CSPAN + 500));
            3:       d = {$urandom, $urandom};
            default: d = 64'($urandom_range(0, 5000));
        endcase
        if ($urandom_range(0, 3) == 0)
            r.from_ns = 64'd0;
        else if (r.from_ns > ALL_ONES - d)
            r.from_ns = ALL_ONES - d;
        r.end_ns = r.from_ns + d;
        if (sel < 70)
        begin
            r.op = OP_RECORD;
            if ($urandom_range(0, 15) == 0)
                r.end_ns = {$urandom, $urandom};
        end
        else if (sel < 95)
        begin
            r.op = OP_QUERY;
            if ($urandom_range(0, 3) != 0)
                r.pct = 14'($urandom_range(1, 9999));
        end
        else if (sel < 97)
            r.op = OP_CLEAR;
        else
            r.op = OP_NONE;
        return r;
    endfunction

    // receiver: random stall pattern, one long hold-off mid-run
    initial
    begin
        int unsigned phase;
        m_axis_tready = 1'b0;
        phase = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            phase++;
            if (phase % 300 < 100)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result check
    always @(posedge clk)
    begin
        stats_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pct_value   = m_axis_tdata[63:0];
            got.rejected    = m_axis_tuser;
            got.valid_count = m_axis_tdata[127:64];
            got.bad_count   = m_axis_tdata[191:128];
            got.least_ns    = m_axis_tdata[255:192];
            got.most_ns     = m_axis_tdata[319:256];
            got.sum_ns      = m_axis_tdata[383:320];
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.pct_value != want.pct_value)
                begin
                    $error("pct_value: exp %0d got %0d", want.pct_value, got.pct_value);
                    errors++;
                end
                if (got.rejected != want.rejected)
                begin
                    $error("sample_rejected: exp %0d got %0d", want.rejected, got.rejected);
                    errors++;
                end
                if (got.valid_count != want.valid_count)
                begin
                    $error("valid_count: exp %0d got %0d", want.valid_count, got.valid_count);
                    errors++;
                end
                if (got.bad_count != want.bad_count)
                begin
                    $error("bad_count: exp %0d got %0d", want.bad_count, got.bad_count);
                    errors++;
                end
                if (got.least_ns != want.least_ns)
                begin
                    $error("least_ns: exp %0d got %0d", want.least_ns, got.least_ns);
                    errors++;
                end
                if (got.most_ns != want.most_ns)
                begin
                    $error("most_ns: exp %0d got %0d", want.most_ns, got.most_ns);
                    errors++;
                end
                if (got.sum_ns != want.sum_ns)
                begin
                    $error("sum_ns: exp %0d got %0d", want.sum_ns, got.sum_ns);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("latency_histogram_percentile_unit_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t   rows [$];
        row_t   rw;
        stats_t z;
        req_t   r;
        int     wait_cycles;

        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NONE;
        clear_hist();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        z = '0;
        z.least_ns = ALL_ONES;
        // empty monitor: query answers 0
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd5000};  rw.known = 1; rw.res = z;
        rows.push_back(rw);
        rw.req = '{OP_NONE, ALL_ONES, 64'd0, 14'h3FFF}; rows.push_back(rw);
        // rejected record
        rw.req = '{OP_RECORD, 64'd10, 64'd9, 14'd0};
        rw.res = z; rw.res.rejected = 1; rw.res.bad_count = 1; rows.push_back(rw);
        rw.known = 0;
        rw.req = '{OP_RECORD, 64'd0, 64'd0, 14'd0};              rows.push_back(rw);
        rw.req = '{OP_RECORD, 64'd0, 64'd255, 14'd0};            rows.push_back(rw);
        rw.req = '{OP_RECORD, 64'd100, 64'd356, 14'd0};          rows.push_back(rw);
        rw.req = '{OP_RECORD, 64'd0, 64'(NEXACT + FSPAN - 1), 14'd0}; rows.push_back(rw);
        rw.req = '{OP_RECORD, 64'd0, 64'(NEXACT + FSPAN), 14'd0}; rows.push_back(rw);
        rw.req = '{OP_RECORD, 64'd0, 64'(NEXACT + FSPAN + CSPAN - 1), 14'd0};
        rows.push_back(rw);
        rw.req = '{OP_RECORD, 64'd0, 64'(NEXACT + FSPAN + CSPAN), 14'd0}; rows.push_back(rw);
        rw.req = '{OP_RECORD, 64'd1, ALL_ONES, 14'd0};           rows.push_back(rw);
        rw.req = '{OP_RECORD, ALL_ONES, ALL_ONES, 14'd0};        rows.push_back(rw);
        rw.req = '{OP_RECORD, ALL_ONES, 64'd0, 14'd0};           rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd0};               rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd1};               rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd5000};            rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd9000};            rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd9999};            rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd10000};           rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'h3FFF};            rows.push_back(rw);
        rw.req = '{OP_NONE, 64'd5, 64'd7, 14'd100};              rows.push_back(rw);
        // clear shows reset values, rejected count included
        rw.req = '{OP_CLEAR, 64'd0, 64'd0, 14'd0}; rw.known = 1; rw.res = z;
        rows.push_back(rw);
        rw.req = '{OP_QUERY, 64'd0, 64'd0, 14'd0};               rows.push_back(rw);

        foreach (rows[i])
            run_item(rows[i].req, rows[i].known, rows[i].res);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                hold_off = 1'b1;
            r = rand_item();
            run_item(r, 1'b0, z);
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("latency_histogram_percentile_unit_tb: PASS");
        else
            $display("latency_histogram_percentile_unit_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lhp_pkg.sv
design/lhp_ram.sv
design/lhp_datapath.sv
design/lhp_ctrl.sv
design/latency_histogram_percentile_unit.sv
design/lhp_checker.sv
tb/latency_histogram_percentile_unit_tb.sv
